// File: rtl/utfsd_pkg.sv
// ----------------------------------------------------------------------------
// utfsd_pkg
// Shared types for the UTF-8 stream decoder: result status codes, the result
// word and the per-byte step bundle passed from the decoder core to the top.
// ----------------------------------------------------------------------------
package utfsd_pkg;

    typedef enum logic [1:0] {
        ST_CHAR = 2'd0,
        ST_BAD  = 2'd1,
        ST_END  = 2'd2
    } t_status;

    typedef struct packed {
        logic [31:0] code_point;
        t_status     status;
        logic        last_of_run;
    } t_result;

    // Results caused by one accepted byte: count is 0, 1 or 2.
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_step;

endpackage

// File: rtl/utfsd_core.sv
// ----------------------------------------------------------------------------
// utfsd_core
// Decoder state and the single-pass decode of one input word into up to two
// results. Sequence state advances only on an accepted word; strict mode loads on a config write.
// ----------------------------------------------------------------------------
module utfsd_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_wdata,
    input  logic             i_accept,
    input  logic [7:0]       i_data_byte,
    input  logic             i_end_of_stream,
    output utfsd_pkg::t_step o_step
);
    import utfsd_pkg::*;

    typedef struct packed {
        logic        emit;
        t_status     status;
        logic [7:0]  code_point;
        logic        open;
        logic [2:0]  level;
        logic [4:0]  payload;
    } t_lead;

    function automatic t_lead lead_decode(input logic [7:0] b);
        t_lead l;
        l = '0;
        casez (b)
            8'b0???_????: begin
                l.emit = 1'b1; l.status = ST_CHAR; l.code_point = b;
            end
            8'b10??_????: begin
                l.emit = 1'b1; l.status = ST_BAD;
            end
            8'b110?_????: begin
                l.open = 1'b1; l.level = 3'd1; l.payload = b[4:0];
            end
            8'b1110_????: begin
                l.open = 1'b1; l.level = 3'd2; l.payload = {1'b0, b[3:0]};
            end
            8'b1111_0???: begin
                l.open = 1'b1; l.level = 3'd3; l.payload = {2'b0, b[2:0]};
            end
            8'b1111_10??: begin
                l.open = 1'b1; l.level = 3'd4; l.payload = {3'b0, b[1:0]};
            end
            8'b1111_110?: begin
                l.open = 1'b1; l.level = 3'd5; l.payload = {3'b0, b[1:0]};
            end
            8'b1111_1110: begin
                l.open = 1'b1; l.level = 3'd6;
            end
            default: begin
                l.emit = 1'b1; l.status = ST_BAD;
            end
        endcase
        return l;
    endfunction

    function automatic logic is_rejected(input logic strict, input logic [2:0] level,
                                         input logic rej, input logic [31:0] v);
        logic r;
        if (!strict) begin
            r = rej;
        end else begin
            case (level)
                3'd1:    r = (v < 32'h0000_0080);
                3'd2:    r = (v < 32'h0000_0800);
                3'd3:    r = (v < 32'h0001_0000);
                default: r = 1'b1;
            endcase
        end
        return r;
    endfunction

    logic        r_strict;
    logic [2:0]  r_rem,   n_rem;
    logic [31:0] r_acc,   n_acc;
    logic [2:0]  r_lvl,   n_lvl;
    logic        r_first, n_first;
    logic        r_rej,   n_rej;

    t_lead       lead;
    logic        em0, em1;
    t_status     st0, st1;
    logic [31:0] cp0, cp1;
    logic [31:0] acc_cont;
    logic [2:0]  rem_cont;
    logic        rej_cont;

    always_comb begin
        lead     = lead_decode(i_data_byte);
        acc_cont = {r_acc[25:0], i_data_byte[5:0]};
        rem_cont = r_rem - 3'd1;
        rej_cont = r_rej | (r_first && (r_lvl == 3'd6) && (i_data_byte[5:0] > 6'h03));

        n_rem   = r_rem;
        n_acc   = r_acc;
        n_lvl   = r_lvl;
        n_first = r_first;
        n_rej   = r_rej;
        em0 = 1'b0; st0 = ST_CHAR; cp0 = '0;
        em1 = 1'b0; st1 = ST_CHAR; cp1 = '0;

        if (i_accept) begin
            if (i_end_of_stream) begin
                // drop any open sequence, flag it, then mark the end
                if (r_rem != 3'd0) begin
                    em0 = 1'b1; st0 = ST_BAD;
                    em1 = 1'b1; st1 = ST_END;
                end else begin
                    em0 = 1'b1; st0 = ST_END;
                end
                n_rem = '0; n_acc = '0; n_lvl = '0; n_first = 1'b0; n_rej = 1'b0;
            end else if (r_rem == 3'd0) begin
                em0 = lead.emit; st0 = lead.status; cp0 = {24'b0, lead.code_point};
            end else if (i_data_byte[7:6] != 2'b10) begin
                // interrupted: flag, then take this word again as a lead
                em0 = 1'b1; st0 = ST_BAD;
                em1 = lead.emit; st1 = lead.status; cp1 = {24'b0, lead.code_point};
                n_rem = '0; n_acc = '0; n_lvl = '0; n_first = 1'b0; n_rej = 1'b0;
            end else begin
                n_first = 1'b0;
                n_rej   = rej_cont;
                n_acc   = acc_cont;
                n_rem   = rem_cont;
                if (rem_cont == 3'd0) begin
                    em0 = 1'b1;
                    if (is_rejected(r_strict, r_lvl, rej_cont, acc_cont)) begin
                        st0 = ST_BAD;
                    end else begin
                        st0 = ST_CHAR; cp0 = acc_cont;
                    end
                    n_acc = '0; n_lvl = '0; n_rej = 1'b0;
                end
            end

            if (lead.open && !i_end_of_stream &&
                (r_rem == 3'd0 || i_data_byte[7:6] != 2'b10)) begin
                n_rem   = lead.level;
                n_lvl   = lead.level;
                n_acc   = {27'b0, lead.payload};
                n_first = 1'b1;
                n_rej   = 1'b0;
            end
        end

        o_step.count            = {1'b0, em0} + {1'b0, em1};
        o_step.res0.code_point  = cp0;
        o_step.res0.status      = st0;
        o_step.res0.last_of_run = ~em1;
        o_step.res1.code_point  = cp1;
        o_step.res1.status      = st1;
        o_step.res1.last_of_run = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strict <= 1'b0;
            r_rem    <= '0;
            r_acc    <= '0;
            r_lvl    <= '0;
            r_first  <= 1'b0;
            r_rej    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_strict <= i_cfg_wdata;
            end
            r_rem   <= n_rem;
            r_acc   <= n_acc;
            r_lvl   <= n_lvl;
            r_first <= n_first;
            r_rej   <= n_rej;
        end
    end

endmodule

// File: rtl/utf8_stream_decoder_unit.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder_unit
// Byte stream in, decoded code points out, with extended leads F8 to FE.
// ----------------------------------------------------------------------------
// Results are registered: a result is offered in the cycle after its byte is accepted.
// Throughput: one byte per cycle while the output is ready; a byte that gives two
//   results holds the input while the two-entry result register drains.
// Reset: synchronous, active low; clears the open sequence, empties the
//   result register and selects lax mode.
module utf8_stream_decoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,     // strict_mode
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] data_byte
    input  logic [0:0]  s_axis_tuser,    // [0] end_of_stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,    // [31:0] code_point
    output logic [1:0]  m_axis_tuser,    // [1:0] status
    output logic        m_axis_tlast     // last_of_run
);
    import utfsd_pkg::*;

    t_step      step;
    logic       accept;
    logic       pop;
    logic [1:0] r_cnt;
    t_result    r_res0;
    t_result    r_res1;

    assign pop           = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;

    utfsd_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_accept        (accept),
        .i_data_byte     (s_axis_tdata),
        .i_end_of_stream (s_axis_tuser[0]),
        .o_step          (step)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (accept) begin
            r_cnt <= step.count;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    // payload: load on accept, advance the second slot on a pop
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res0 <= step.res0;
            r_res1 <= step.res1;
        end else if (pop) begin
            r_res0 <= r_res1;
        end
    end

    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign m_axis_tdata  = r_res0.code_point;
    assign m_axis_tuser  = r_res0.status;
    assign m_axis_tlast  = r_res0.last_of_run;

endmodule

// File: rtl/utfsd_checker.sv
// ----------------------------------------------------------------------------
// utfsd_checker
// Port-level checks on the decoder's output stream, bound to the top level.
// ----------------------------------------------------------------------------
module utfsd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    import utfsd_pkg::*;

    // hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // a non-final result is always followed by its partner
    a_pair_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
        else $error("second result of a pair missing");

    a_pair_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input taken while a pair is pending");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_END) |-> m_axis_tlast)
        else $error("end of stream not last of run");

    a_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != ST_CHAR) |-> (m_axis_tdata == 32'd0))
        else $error("non-character result carries data");

endmodule

bind utf8_stream_decoder_unit utfsd_checker u_utfsd_checker (.*);
